[src/ufr_pkg.sv]
// shared types, codes and constants for the uart receive fifo register block
// no dependencies; imported by ufr_ctrl, ufr_dp and the top level, not by ufr_ram
`default_nettype none

package ufr_pkg;

    // default receive fifo depth in bytes
    localparam int FIFO_DEPTH_DEF = 8;

    // answer of an rx data read while the fifo is empty
    localparam logic [31:0] RX_EMPTY_WORD = 32'h8000_0000;

    // watermark count field inside the tx and rx control words
    localparam int WM_LSB = 16;
    localparam int WM_W   = 3;

    // stream word layout
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;

    // item kinds carried in tuser
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_RX    = 2'd2;

    // bus register indexes
    localparam logic [2:0] REG_TXDATA = 3'd0;
    localparam logic [2:0] REG_RXDATA = 3'd1;
    localparam logic [2:0] REG_TXCTRL = 3'd2;
    localparam logic [2:0] REG_RXCTRL = 3'd3;
    localparam logic [2:0] REG_IE     = 3'd4;
    localparam logic [2:0] REG_IP     = 3'd5;
    localparam logic [2:0] REG_DIV    = 3'd6;

    // configuration port register indexes
    localparam logic [1:0] CFG_IE     = 2'd0;
    localparam logic [1:0] CFG_TXCTRL = 2'd1;
    localparam logic [1:0] CFG_RXCTRL = 2'd2;
    localparam logic [1:0] CFG_DIV    = 2'd3;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RAM_WAIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;      // word taken, update pointers and issue any ram read
        logic load_direct; // load result register from the word just taken
        logic load_ram;    // load result register from the ram read data
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_pop;      // offered word pops a byte from the fifo
    } t_dp_status;

endpackage

`default_nettype wire

[src/ufr_ram.sv]
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module ufr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic                                 i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/ufr_ctrl.sv]
// controller: input handshake, ram read wait, result register valid
// depends on ufr_pkg
`default_nettype none

module ufr_ctrl
    import ufr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && out_free && i_status.is_pop) begin
                    n_state = ST_RAM_WAIT;
                end
            end
            ST_RAM_WAIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready        = 1'b0;
        o_cmd.accept      = 1'b0;
        o_cmd.load_direct = 1'b0;
        o_cmd.load_ram    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready        = out_free;
                o_cmd.accept      = i_in_valid && out_free;
                o_cmd.load_direct = i_in_valid && out_free && !i_status.is_pop;
            end
            ST_RAM_WAIT: begin
                o_cmd.load_ram = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_direct || o_cmd.load_ram) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // an accepted pop always enters the ram wait state in the following cycle
    a_pop_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept && i_status.is_pop |=> r_state == ST_RAM_WAIT)
        else $error("pop did not enter ram wait");

    // no new word while a pop result is pending
    a_no_accept_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RAM_WAIT |-> !o_in_ready)
        else $error("word accepted during ram wait");

    // a result is never loaded over one that nobody took
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_direct || o_cmd.load_ram) |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

endmodule

`default_nettype wire

[src/ufr_dp.sv]
// datapath: fifo pointers and ram, config registers, result register
// depends on ufr_pkg and ufr_ram
`default_nettype none

module ufr_dp
    import ufr_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [1:0]            i_cmd_kind,
    input  wire logic [2:0]            i_reg_index,
    input  wire logic [7:0]            i_write_byte,
    input  wire logic [7:0]            i_rx_byte,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_status                 o_status,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_waddr,
    input  wire logic [31:0]           i_cfg_wdata,
    input  wire logic [1:0]            i_cfg_raddr,
    output logic      [31:0]           o_cfg_rdata,
    output logic      [OUT_DATA_W-1:0] o_result
);

    localparam int AW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW   = $clog2(FIFO_DEPTH + 1);
    localparam int CMPW = (CW > WM_W) ? CW : WM_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

    logic [1:0]  r_irq_enable;
    logic [31:0] r_tx_control;
    logic [31:0] r_rx_control;
    logic [31:0] r_baud_divisor;

    logic [AW-1:0] r_rd_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] n_wr_ptr;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] n_fill;

    logic [OUT_DATA_W-1:0] r_result;
    logic [7:0]            ram_rdata;

    logic        is_pop;
    logic        push_ok;
    logic        dropped;
    logic [31:0] pending;
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq;
    logic        rx_space;

    // config registers, written only from the apb port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_enable   <= '0;
            r_tx_control   <= '0;
            r_rx_control   <= '0;
            r_baud_divisor <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_waddr)
                CFG_IE:     r_irq_enable   <= i_cfg_wdata[1:0];
                CFG_TXCTRL: r_tx_control   <= i_cfg_wdata;
                CFG_RXCTRL: r_rx_control   <= i_cfg_wdata;
                CFG_DIV:    r_baud_divisor <= i_cfg_wdata;
                default:    r_baud_divisor <= r_baud_divisor;
            endcase
        end
    end

    always_comb begin
        unique case (i_cfg_raddr)
            CFG_IE:     o_cfg_rdata = {30'd0, r_irq_enable};
            CFG_TXCTRL: o_cfg_rdata = r_tx_control;
            CFG_RXCTRL: o_cfg_rdata = r_rx_control;
            CFG_DIV:    o_cfg_rdata = r_baud_divisor;
            default:    o_cfg_rdata = '0;
        endcase
    end

    assign is_pop  = (i_cmd_kind == CMD_READ) && (i_reg_index == REG_RXDATA)
                     && (r_fill != '0);
    assign push_ok = (i_cmd_kind == CMD_RX) && (r_fill != FULL_CNT);
    assign dropped = (i_cmd_kind == CMD_RX) && (r_fill == FULL_CNT);
    assign o_status.is_pop = is_pop;

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_fill   = r_fill;
        if (i_cmd.accept && is_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            n_fill   = r_fill - 1'b1;
        end else if (i_cmd.accept && push_ok) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
            n_fill   = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_fill   <= n_fill;
        end
    end

    ufr_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && push_ok),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.accept && is_pop),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        pending    = '0;
        pending[0] = (r_tx_control[WM_LSB +: WM_W] != '0);
        pending[1] = CMPW'(r_fill) > CMPW'(r_rx_control[WM_LSB +: WM_W]);
    end

    always_comb begin
        read_data = '0;
        if (i_cmd_kind == CMD_READ) begin
            unique case (i_reg_index)
                REG_RXDATA: read_data = RX_EMPTY_WORD;
                REG_TXCTRL: read_data = r_tx_control;
                REG_RXCTRL: read_data = r_rx_control;
                REG_IE:     read_data = {30'd0, r_irq_enable};
                REG_IP:     read_data = pending;
                REG_DIV:    read_data = r_baud_divisor;
                default:    read_data = '0;
            endcase
        end
    end

    assign tx_valid = (i_cmd_kind == CMD_WRITE) && (i_reg_index == REG_TXDATA);
    assign tx_byte  = tx_valid ? i_write_byte : 8'd0;
    assign irq      = r_irq_enable[1] && (n_fill != '0);
    assign rx_space = (n_fill != FULL_CNT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_direct) begin
            r_result <= {4'd0, dropped, rx_space, irq, tx_byte, tx_valid, read_data};
        end else if (i_cmd.load_ram) begin
            r_result <= {4'd0, 1'b0, rx_space, irq, 8'd0, 1'b0, 24'd0, ram_rdata};
        end
    end

    assign o_result = r_result;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("fill count above depth");

    // read and write pointers meet when empty or full
    a_ptr_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0 || r_fill == FULL_CNT) |-> r_rd_ptr == r_wr_ptr)
        else $error("pointers disagree with fill count");

endmodule

`default_nettype wire

[src/uart_rx_fifo_register_block.sv]
// top level of the uart receive fifo register block
// depends on ufr_pkg, ufr_ctrl, ufr_dp (which holds ufr_ram)
//
// usage
// - slave stream: one word per event. tuser is the kind (bus read, bus
//   write, byte arriving from the line); tdata carries the register
//   index, the bus write byte and the arriving line byte
// - master stream: one result word per input word, in order: bus read
//   data, transmit strobe and byte, interrupt level, fifo space flag and
//   the dropped flag of an arriving byte
// - apb port writes and reads back irq_enable, tx_control, rx_control and
//   baud_divisor at byte addresses 0, 4, 8, 12; pready is always high
// flow
// - a word that does not pop the fifo gives its result in the result
//   register in the cycle after acceptance; one word per cycle unless stalled
// - a pop of the rx data register reads the fifo ram, whose read port is
//   registered, then loads the result register; no new word is taken meanwhile
// reset
// - synchronous, active low: fifo empty, config registers zero, no result
// stall
// - a result waits in the output register; a new word is taken in the
//   cycle the waiting result leaves, so nothing is lost or repeated
`default_nettype none

module uart_rx_fifo_register_block
    import ufr_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [2:0] reg_index, [10:3] write_byte, [18:11] rx_byte, rest zero
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] cmd
    input  wire logic [IN_USER_W-1:0]  i_s_axis_tuser,

    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [31:0] read_data, [32] tx_valid, [40:33] tx_byte, [41] irq,
    // [42] rx_space, [43] rx_dropped, rest zero
    output logic      [OUT_DATA_W-1:0] o_m_axis_tdata,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       cfg_we;

    // register write on the access phase
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    ufr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    ufr_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_kind   (i_s_axis_tuser[1:0]),
        .i_reg_index  (i_s_axis_tdata[2:0]),
        .i_write_byte (i_s_axis_tdata[10:3]),
        .i_rx_byte    (i_s_axis_tdata[18:11]),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_cfg_we     (cfg_we),
        .i_cfg_waddr  (paddr[3:2]),
        .i_cfg_wdata  (pwdata),
        .i_cfg_raddr  (paddr[3:2]),
        .o_cfg_rdata  (prdata),
        .o_result     (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

[verif/testbench.sv]
// self-checking testbench for uart_rx_fifo_register_block
// stream stimulus and response checking plus apb register programming
// depends on ufr_pkg and the block rtl under src
`default_nettype none

module testbench;
    import ufr_pkg::*;

    // fifo depth used by the instance and by the local predictor
    localparam int DEPTH = FIFO_DEPTH_DEF;
    localparam int PTR_W = $clog2(DEPTH);

    // unused item kind, must leave all state alone
    localparam logic [1:0] CMD_NONE = 2'd3;

    // index 7 of the bus register map has no register behind it
    localparam logic [2:0] REG_NONE = 3'd7;

    // random part, split over phases with different settings
    localparam int PHASES         = 5;
    localparam int WORDS_PER_PHASE = 140;

    // one input word as the block sees it
    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] idx;
        logic [7:0] wbyte;
        logic [7:0] rbyte;
    } t_event;

    // one result word, split into its fields
    typedef struct packed {
        logic [31:0] read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        irq;
        logic        rx_space;
        logic        rx_dropped;
    } t_result;

    // clock, reset and block ports; every input has a known value from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [3:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // words waiting to be driven, and results still owed by the block
    t_event  events_to_send[$];
    t_result resp_due[$];

    // bookkeeping shared between the stimulus, the driver and the monitor
    int unsigned n_queued   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_errors   = 0;
    logic        word_taken = 1'b0;
    logic        calm       = 1'b0;
    t_event      ev_out;

    // predictor copy of the fifo and the registers
    logic [7:0]       rx_bytes[DEPTH];
    logic [PTR_W-1:0] rd_ptr = '0;
    logic [PTR_W:0]   fill = '0;
    logic [1:0]       cfg_ie = '0;
    logic [31:0]      cfg_txctrl = '0;
    logic [31:0]      cfg_rxctrl = '0;
    logic [31:0]      cfg_div = '0;

    uart_rx_fifo_register_block #(
        .FIFO_DEPTH(DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // period of 4 time units
    always #2 i_clk = ~i_clk;

    // expected response to one word; updates the predictor fifo as the block would
    function automatic t_result next_response(t_event ev);
        t_result          r;
        logic [PTR_W-1:0] slot;
        r = '0;
        case (ev.cmd)
            CMD_READ: begin
                case (ev.idx)
                    REG_RXDATA: begin
                        if (fill != 0) begin
                            r.read_data = {24'd0, rx_bytes[rd_ptr]};
                            rd_ptr = rd_ptr + 1'b1;
                            fill = fill - 1'b1;
                        end else begin
                            r.read_data = RX_EMPTY_WORD;
                        end
                    end
                    REG_TXCTRL: r.read_data = cfg_txctrl;
                    REG_RXCTRL: r.read_data = cfg_rxctrl;
                    REG_IE:     r.read_data = {30'd0, cfg_ie};
                    REG_IP:     r.read_data = {30'd0,
                                               fill > cfg_rxctrl[WM_LSB +: WM_W],
                                               cfg_txctrl[WM_LSB +: WM_W] != 0};
                    REG_DIV:    r.read_data = cfg_div;
                    default:    r.read_data = '0;
                endcase
            end
            CMD_WRITE: begin
                // only the tx data register reacts to a bus write
                if (ev.idx == REG_TXDATA) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = ev.wbyte;
                end
            end
            CMD_RX: begin
                if (fill == DEPTH) begin
                    r.rx_dropped = 1'b1;
                end else begin
                    slot = rd_ptr + fill[PTR_W-1:0];
                    rx_bytes[slot] = ev.rbyte;
                    fill = fill + 1'b1;
                end
            end
            default: ;
        endcase
        r.irq      = cfg_ie[1] && (fill != 0);
        r.rx_space = fill < DEPTH;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    // driver: inputs move on the falling edge only, one assignment per signal
    always @(negedge i_clk) begin
        i_m_axis_tready <= calm || ($urandom_range(99) >= 24);
        if (i_rst_n && (!i_s_axis_tvalid || word_taken)) begin
            if (events_to_send.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
                ev_out = events_to_send.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {5'd0, ev_out.rbyte, ev_out.wbyte, ev_out.idx};
                i_s_axis_tuser  <= ev_out.cmd;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: sample both streams at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= i_s_axis_tvalid && o_s_axis_tready;

            // a result leaving now always belongs to an earlier word
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (resp_due.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, o_m_axis_tdata);
                end else begin
                    t_result want;
                    want = resp_due.pop_front();
                    check_field("read_data", want.read_data, o_m_axis_tdata[31:0]);
                    check_field("tx_valid", 32'(want.tx_valid), 32'(o_m_axis_tdata[32]));
                    check_field("tx_byte", 32'(want.tx_byte), 32'(o_m_axis_tdata[40:33]));
                    check_field("irq", 32'(want.irq), 32'(o_m_axis_tdata[41]));
                    check_field("rx_space", 32'(want.rx_space), 32'(o_m_axis_tdata[42]));
                    check_field("rx_dropped", 32'(want.rx_dropped),
                                32'(o_m_axis_tdata[43]));
                end
            end

            // word taken: predict its result from the sampled inputs
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                t_event ev_in;
                ev_in.cmd   = i_s_axis_tuser;
                ev_in.idx   = i_s_axis_tdata[2:0];
                ev_in.wbyte = i_s_axis_tdata[10:3];
                ev_in.rbyte = i_s_axis_tdata[18:11];
                resp_due.push_back(next_response(ev_in));
                n_accepted++;
            end
        end
    end

    task automatic queue_event(input logic [1:0] cmd, input logic [2:0] idx,
                               input logic [7:0] wbyte, input logic [7:0] rbyte);
        t_event ev;
        ev.cmd   = cmd;
        ev.idx   = idx;
        ev.wbyte = wbyte;
        ev.rbyte = rbyte;
        events_to_send.push_back(ev);
        n_queued++;
    endtask

    // random word; rx_pct steers how fast the fifo fills against pops
    task automatic queue_random(input int unsigned rx_pct);
        int unsigned r;
        logic [1:0]  cmd;
        logic [2:0]  idx;
        r   = $urandom_range(99);
        idx = 3'($urandom_range(7));
        if (r < rx_pct) begin
            cmd = CMD_RX;
        end else if (r < 88) begin
            cmd = CMD_READ;
            // at least half the reads address the rx data register
            if ($urandom_range(1)) idx = REG_RXDATA;
        end else if (r < 98) begin
            cmd = CMD_WRITE;
            if ($urandom_range(1)) idx = REG_TXDATA;
        end else begin
            cmd = CMD_NONE;
        end
        queue_event(cmd, idx, 8'($urandom), 8'($urandom));
    endtask

    // wait until every queued word is taken and every result has come back
    task automatic drain();
        while (n_accepted != n_queued || resp_due.size() != 0)
            @(posedge i_clk);
    endtask

    // apb write, then read back; only called while the block is idle
    task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        // register written at the edge just passed; mirror it
        case (idx)
            CFG_IE:     cfg_ie = value[1:0];
            CFG_TXCTRL: cfg_txctrl = value;
            CFG_RXCTRL: cfg_rxctrl = value;
            default:    cfg_div = value;
        endcase
        want = (idx == CFG_IE) ? {30'd0, value[1:0]} : value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_field("apb readback", want, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stimulus
    initial begin
        int unsigned rx_pct;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // both watermark enables on, tx count at its top, rx count 3
        write_csr(CFG_IE, 32'h0000_0003);
        write_csr(CFG_TXCTRL, 32'hFFFF_FFFF);
        write_csr(CFG_RXCTRL, 32'h0003_0000);
        write_csr(CFG_DIV, 32'h0000_0000);

        // directed: empty pop, reads of unused indexes, transmit extremes
        queue_event(CMD_READ, REG_RXDATA, 8'h00, 8'h00);
        queue_event(CMD_READ, REG_TXDATA, 8'hFF, 8'hFF);
        queue_event(CMD_READ, REG_NONE, 8'h00, 8'h00);
        queue_event(CMD_WRITE, REG_TXDATA, 8'h00, 8'hFF);
        queue_event(CMD_WRITE, REG_TXDATA, 8'hFF, 8'h00);
        // writes that must be ignored, and the unused kind
        queue_event(CMD_WRITE, REG_RXCTRL, 8'hFF, 8'hFF);
        queue_event(CMD_WRITE, REG_NONE, 8'hA5, 8'h5A);
        queue_event(CMD_NONE, REG_RXDATA, 8'hFF, 8'hFF);
        // fill the fifo to the brim, then one byte too many is dropped
        queue_event(CMD_RX, REG_TXDATA, 8'h00, 8'hFF);
        queue_event(CMD_RX, REG_TXDATA, 8'h00, 8'h00);
        for (int i = 0; i < DEPTH - 1; i++)
            queue_event(CMD_RX, REG_TXDATA, 8'h00, 8'($urandom));
        // pending word with a full fifo, then the config registers read over the bus
        queue_event(CMD_READ, REG_IP, 8'h00, 8'h00);
        queue_event(CMD_READ, REG_IE, 8'h00, 8'h00);
        queue_event(CMD_READ, REG_TXCTRL, 8'h00, 8'h00);
        queue_event(CMD_READ, REG_RXCTRL, 8'h00, 8'h00);
        queue_event(CMD_READ, REG_DIV, 8'h00, 8'h00);
        // pops wrap the read pointer later in the random part
        queue_event(CMD_READ, REG_RXDATA, 8'h00, 8'h00);
        queue_event(CMD_READ, REG_RXDATA, 8'h00, 8'h00);
        queue_event(CMD_NONE, REG_NONE, 8'h00, 8'h00);
        drain();

        // random phases; the sender holds off between them until all results are in
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    write_csr(CFG_IE, 32'h0000_0000);
                    write_csr(CFG_TXCTRL, 32'h0000_0000);
                    write_csr(CFG_RXCTRL, 32'hFFFF_FFFF);
                    write_csr(CFG_DIV, 32'hFFFF_FFFF);
                    rx_pct = 20;
                end
                1: begin
                    write_csr(CFG_IE, 32'hFFFF_FFFF);
                    write_csr(CFG_TXCTRL, $urandom);
                    write_csr(CFG_RXCTRL, 32'h0000_0000);
                    write_csr(CFG_DIV, $urandom);
                    rx_pct = 50;
                end
                2: begin
                    write_csr(CFG_IE, 32'h0000_0002);
                    write_csr(CFG_TXCTRL, 32'h0001_0000);
                    write_csr(CFG_RXCTRL, 32'h0007_0000);
                    write_csr(CFG_DIV, 32'h0000_0001);
                    rx_pct = 70;
                end
                3: begin
                    write_csr(CFG_IE, 32'h0000_0001);
                    write_csr(CFG_TXCTRL, 32'hFFF8_FFFF);
                    write_csr(CFG_RXCTRL, $urandom);
                    write_csr(CFG_DIV, $urandom);
                    rx_pct = 35;
                end
                default: begin
                    write_csr(CFG_IE, $urandom);
                    write_csr(CFG_TXCTRL, $urandom);
                    write_csr(CFG_RXCTRL, 32'h0000_FFFF);
                    write_csr(CFG_DIV, 32'h8000_0000);
                    rx_pct = 45;
                end
            endcase
            // one whole phase runs with no idling on either side
            calm = (ph == 2);
            for (int i = 0; i < WORDS_PER_PHASE; i++)
                queue_random(rx_pct);
            drain();
        end
        calm = 1'b0;

        // wait for any stray word after the last result
        repeat (10) @(posedge i_clk);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
